### rtl/fbpa_pkg.sv
// Shared types, register map and constants of the block pool allocator.
package fbpa_pkg;

    localparam int DEF_MAX_BLOCKS = 256;
    localparam int DEF_ADDR_WIDTH = 32;

    localparam int CNT_W   = 9;
    localparam int SIZE_W  = 16;
    localparam int BASE_W  = 32;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [BASE_W-1:0] RST_BASE  = 32'd4096;
    localparam logic [SIZE_W-1:0] RST_SIZE  = 16'd16;
    localparam logic [CNT_W-1:0]  RST_COUNT = 9'd256;
    localparam logic [SIZE_W-1:0] MIN_SIZE  = 16'd4;

    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_SIZE  = 2'd1,
        REG_COUNT = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_INVALID  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Effective configuration as seen by the sequencer.
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  count;
        logic              rebuild;
    } cfg_t;

endpackage

### rtl/fixed_block_pool_allocator.sv
// Top level of the fixed-size block pool allocator: sequencer, stack and marks.
//
//  Channel   Direction  Handshake            Beat contents
//  req       in         req_valid/req_ready  op, free_address
//  rsp       out        rsp_valid/rsp_ready  status, block_address, free_count, available
//  apb       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// An allocate pops the free stack and then forms base plus index times size; a free
// subtracts the base, checks the range, divides the offset by the size and checks the
// index and its mark. The single shared adder runs one bit per cycle through the
// index-times-size product or through the offset-by-size division.
// After reset, and after every write to a defined register, the allocated marks are
// cleared by a pass over every block during which req_ready stays low.
// A finished response waits in its output register; the next request is taken as soon
// as the sequencer is back in idle, and only a response that finds the register still
// full holds the sequencer until rsp_ready.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic                  op,
    input  logic [ADDR_WIDTH-1:0] free_address,

    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [1:0]            status,
    output logic [ADDR_WIDTH-1:0] block_address,
    output logic [CNT_W-1:0]      free_count,
    output logic                  available,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    // Block index width, datapath width of the shared adder, and step counter width.
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int DW    = ((ADDR_WIDTH > SIZE_W + IDX_W) ? ADDR_WIDTH : SIZE_W + IDX_W) + 1;
    localparam int KW    = $clog2(IDX_W + 1);
    localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(MAX_BLOCKS - 1);
    localparam logic [KW-1:0]    STEP_LAST  = KW'(IDX_W - 1);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_OFF      = 11'b000_0000_0010,
        S_RANGE    = 11'b000_0000_0100,
        S_DIV      = 11'b000_0000_1000,
        S_CHECK    = 11'b000_0001_0000,
        S_MARK_CHK = 11'b000_0010_0000,
        S_POP_RD   = 11'b000_0100_0000,
        S_POP_DATA = 11'b000_1000_0000,
        S_MUL      = 11'b001_0000_0000,
        S_BASE     = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    cfg_t cfg;

    // Control state.
    state_t            state_reg,        state_next;
    logic [CNT_W-1:0]  fb_reg,           fb_next;
    logic [CNT_W-1:0]  lw_reg,           lw_next;
    logic              sweep_active_reg, sweep_active_next;
    logic [IDX_W-1:0]  sweep_idx_reg,    sweep_idx_next;
    logic              rsp_valid_reg,    rsp_valid_next;
    logic [KW-1:0]     cnt_reg,          cnt_next;

    // Working payload.
    logic [ADDR_WIDTH-1:0] addr_reg,   addr_next;
    logic [DW-1:0]         rem_reg,    rem_next;
    logic [DW-1:0]         dvs_reg,    dvs_next;
    logic [DW-1:0]         acc_reg,    acc_next;
    logic [IDX_W-1:0]      q_reg,      q_next;
    logic [IDX_W-1:0]      mul_sr_reg, mul_sr_next;
    status_t               st_reg,     st_next;
    logic [ADDR_WIDTH-1:0] baddr_reg,  baddr_next;

    // Response register.
    status_t               status_out_reg;
    logic [ADDR_WIDTH-1:0] baddr_out_reg;
    logic [CNT_W-1:0]      fcount_out_reg;
    logic                  rsp_load;

    // Shared adder.
    logic [DW-1:0] alu_a, alu_b, alu_y;
    logic          alu_sub, alu_c;

    // Memories: the free stack holds block indices, bottom at position zero.
    logic             stack_we;
    logic [IDX_W-1:0] stack_waddr, stack_raddr, stack_rdata;
    logic             mark_we;
    logic [IDX_W-1:0] mark_waddr;
    logic             mark_wdata, mark_rdata;

    logic [ADDR_WIDTH-1:0] base_aw;
    logic [CNT_W-1:0]      fb_dec;
    logic [IDX_W-1:0]      pos_top, idx_sel;

    fbpa_cfg #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    fbpa_alu #(
        .DW (DW)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .y     (alu_y),
        .carry (alu_c)
    );

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (q_reg),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // One bit per block: set while the block is handed out.
    fbpa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_marks (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (q_reg),
        .rdata (mark_rdata)
    );

    assign pready    = 1'b1;
    assign req_ready = state_reg == S_IDLE && !sweep_active_reg && !cfg.rebuild;
    assign base_aw   = ADDR_WIDTH'(cfg.base);

    // Stack positions below the low-water mark have not been written since the last
    // rebuild, so their RAM contents are not used: position p stands for block p.
    assign fb_dec      = fb_reg - CNT_W'(1);
    assign pos_top     = IDX_W'(fb_dec);
    assign stack_raddr = pos_top;
    assign stack_waddr = IDX_W'(fb_reg);
    assign idx_sel     = (fb_dec < lw_reg) ? pos_top : stack_rdata;

    always_comb
    begin
        state_next        = state_reg;
        fb_next           = fb_reg;
        lw_next           = lw_reg;
        sweep_active_next = sweep_active_reg;
        sweep_idx_next    = sweep_idx_reg;
        cnt_next          = cnt_reg;
        addr_next         = addr_reg;
        rem_next          = rem_reg;
        dvs_next          = dvs_reg;
        acc_next          = acc_reg;
        q_next            = q_reg;
        mul_sr_next       = mul_sr_reg;
        st_next           = st_reg;
        baddr_next        = baddr_reg;
        rsp_load          = 1'b0;
        alu_a             = '0;
        alu_b             = '0;
        alu_sub           = 1'b0;
        stack_we          = 1'b0;
        mark_we           = 1'b0;
        mark_waddr        = sweep_idx_reg;
        mark_wdata        = 1'b0;

        // Clearing pass over the allocated marks.
        if (sweep_active_reg)
        begin
            mark_we        = 1'b1;
            sweep_idx_next = sweep_idx_reg + IDX_W'(1);
            if (sweep_idx_reg == SWEEP_LAST)
            begin
                sweep_active_next = 1'b0;
            end
        end

        if (cfg.rebuild)
        begin
            fb_next           = cfg.count;
            lw_next           = cfg.count;
            sweep_active_next = 1'b1;
            sweep_idx_next    = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    addr_next  = free_address;
                    baddr_next = '0;
                    if (op == OP_FREE)
                    begin
                        state_next = S_OFF;
                    end
                    else if (fb_reg == '0)
                    begin
                        st_next    = ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_POP_RD;
                    end
                end
            end
            S_OFF:
            begin
                alu_a    = DW'(addr_reg);
                alu_b    = DW'(base_aw);
                alu_sub  = 1'b1;
                rem_next = DW'(alu_y[ADDR_WIDTH-1:0]);
                if (addr_reg == '0)
                begin
                    st_next    = ST_INVALID;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                // An offset past the largest pool this block can hold is rejected here,
                // which also keeps the quotient within IDX_W bits.
                alu_a   = rem_reg;
                alu_b   = DW'(cfg.size) << IDX_W;
                alu_sub = 1'b1;
                if (alu_c)
                begin
                    st_next    = ST_INVALID;
                    state_next = S_DONE;
                end
                else
                begin
                    dvs_next   = DW'(cfg.size) << (IDX_W - 1);
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                alu_a   = rem_reg;
                alu_b   = dvs_reg;
                alu_sub = 1'b1;
                if (alu_c)
                begin
                    rem_next = alu_y;
                end
                q_next   = (q_reg << 1) | IDX_W'(alu_c);
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg + KW'(1);
                if (cnt_reg == STEP_LAST)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // The mark of block q is read here and checked in the next state.
                if (rem_reg != '0 || CMP_W'(q_reg) >= CMP_W'(cfg.count))
                begin
                    st_next    = ST_INVALID;
                    state_next = S_DONE;
                end
                else if (fb_reg >= cfg.count)
                begin
                    st_next    = ST_OVERFLOW;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MARK_CHK;
                end
            end
            S_MARK_CHK:
            begin
                if (!mark_rdata)
                begin
                    st_next = ST_OVERFLOW;
                end
                else
                begin
                    mark_we    = 1'b1;
                    mark_waddr = q_reg;
                    mark_wdata = 1'b0;
                    stack_we   = 1'b1;
                    fb_next    = fb_reg + CNT_W'(1);
                    st_next    = ST_OK;
                end
                state_next = S_DONE;
            end
            S_POP_RD:
            begin
                state_next = S_POP_DATA;
            end
            S_POP_DATA:
            begin
                mark_we     = 1'b1;
                mark_waddr  = idx_sel;
                mark_wdata  = 1'b1;
                fb_next     = fb_dec;
                lw_next     = (fb_dec < lw_reg) ? fb_dec : lw_reg;
                mul_sr_next = idx_sel;
                acc_next    = '0;
                cnt_next    = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                // Shift-and-add of index times size, most significant index bit first.
                alu_a       = acc_reg << 1;
                alu_b       = mul_sr_reg[IDX_W-1] ? DW'(cfg.size) : '0;
                acc_next    = alu_y;
                mul_sr_next = mul_sr_reg << 1;
                cnt_next    = cnt_reg + KW'(1);
                if (cnt_reg == STEP_LAST)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                alu_a      = acc_reg;
                alu_b      = DW'(base_aw);
                baddr_next = alu_y[ADDR_WIDTH-1:0];
                st_next    = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fb_reg           <= '0;
            lw_reg           <= '0;
            sweep_active_reg <= 1'b1;
            sweep_idx_reg    <= '0;
            rsp_valid_reg    <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            fb_reg           <= fb_next;
            lw_reg           <= lw_next;
            sweep_active_reg <= sweep_active_next;
            sweep_idx_reg    <= sweep_idx_next;
            rsp_valid_reg    <= rsp_valid_next;
            cnt_reg          <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        acc_reg    <= acc_next;
        q_reg      <= q_next;
        mul_sr_reg <= mul_sr_next;
        st_reg     <= st_next;
        baddr_reg  <= baddr_next;
        if (rsp_load)
        begin
            status_out_reg <= st_reg;
            baddr_out_reg  <= baddr_reg;
            fcount_out_reg <= fb_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_out_reg;
    assign block_address = baddr_out_reg;
    assign free_count    = fcount_out_reg;
    assign available     = fcount_out_reg != '0;

    // The free count never exceeds the effective pool size outside a rebuild.
    a_fb_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.rebuild |-> fb_reg <= cfg.count)
        else $error("free count exceeds pool size");

    // The low-water mark of the stack never lies above the current fill.
    a_lw_below_fb: assert property (@(posedge clk) disable iff (!rst_n)
        lw_reg <= fb_reg)
        else $error("stack low-water mark above fill");

    // An empty report always comes with a zero free count.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> free_count == '0 && !available)
        else $error("empty status with blocks free");

endmodule

### rtl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/fbpa_alu.sv
// Shared add/subtract unit with carry out, used by the address arithmetic of the sequencer.
module fbpa_alu #(
    parameter int DW = 33
) (
    input  logic [DW-1:0] a,
    input  logic [DW-1:0] b,
    input  logic          sub,
    output logic [DW-1:0] y,
    output logic          carry
);

    logic [DW:0] sum;

    // With sub set, carry high means a >= b (no borrow).
    assign sum   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (DW + 1)'(sub);
    assign y     = sum[DW-1:0];
    assign carry = sum[DW];

endmodule

### rtl/fbpa_cfg.sv
// Configuration registers, read-back and the rebuild request they raise.
module fbpa_cfg
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg
);

    logic [BASE_W-1:0] base_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              rebuild_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign idx   = reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= RST_BASE;
            size_reg    <= RST_SIZE;
            count_reg   <= RST_COUNT;
            rebuild_reg <= 1'b1;
        end
        else
        begin
            rebuild_reg <= 1'b0;
            if (wr_en)
            begin
                unique case (idx)
                    REG_BASE:
                    begin
                        base_reg    <= pwdata;
                        rebuild_reg <= 1'b1;
                    end
                    REG_SIZE:
                    begin
                        size_reg    <= pwdata[SIZE_W-1:0];
                        rebuild_reg <= 1'b1;
                    end
                    REG_COUNT:
                    begin
                        count_reg   <= pwdata[CNT_W-1:0];
                        rebuild_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BASE:  prdata = base_reg;
            REG_SIZE:  prdata = PDATA_W'(size_reg);
            REG_COUNT: prdata = PDATA_W'(count_reg);
            default:   prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.base    = base_reg;
        cfg.size    = (size_reg < MIN_SIZE) ? MIN_SIZE : size_reg;
        cfg.count   = (int'(count_reg) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : count_reg;
        cfg.rebuild = rebuild_reg;
    end

endmodule

### verif/fbpa_checker.sv
`timescale 1ns / 100ps
// Checker for the block pool allocator: mirrors the free list and compares every response beat.
module fbpa_checker
    import fbpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               req_valid,
    input  logic               req_ready,
    input  logic               op,
    input  logic [BASE_W-1:0]  free_address,

    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  logic [1:0]         status,
    input  logic [BASE_W-1:0]  block_address,
    input  logic [CNT_W-1:0]   free_count,
    input  logic               available,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,

    output int                 errors,
    output int                 in_flight
);

    localparam int NBLK = DEF_MAX_BLOCKS;

    typedef struct {
        status_t           status;
        logic [BASE_W-1:0] addr;
        logic [CNT_W-1:0]  count;
        logic              avail;
    } outcome_t;

    logic [BASE_W-1:0] cfg_base;
    logic [SIZE_W-1:0] cfg_size;
    logic [CNT_W-1:0]  cfg_count;

    // Free list image: link per block, list head, per-block free mark, free total.
    int unsigned link_of [NBLK];
    int unsigned top_idx;
    bit          is_free [NBLK];
    int unsigned nfree;

    outcome_t    outcome_q [$];
    int          fail_cnt = 0;
    int          pending_cnt = 0;

    assign errors    = fail_cnt;
    assign in_flight = pending_cnt;

    function automatic int unsigned pool_blocks();
        if (cfg_count > NBLK)
            return NBLK;
        return cfg_count;
    endfunction

    function automatic longint unsigned unit_bytes();
        if (cfg_size < MIN_SIZE)
            return MIN_SIZE;
        return cfg_size;
    endfunction

    function automatic void rebuild_list();
        int unsigned n;
        n = pool_blocks();
        for (int i = 0; i < NBLK; i++)
        begin
            link_of[i] = (i > 0) ? i - 1 : 0;
            is_free[i] = (i < n);
        end
        top_idx = (n > 0) ? n - 1 : 0;
        nfree   = n;
    endfunction

    function automatic outcome_t predict_pool_op(op_t kind, logic [BASE_W-1:0] addr);
        outcome_t          o;
        longint unsigned   sz;
        longint unsigned   off;
        longint unsigned   wide;
        logic [BASE_W-1:0] diff;
        int unsigned       n;
        int unsigned       idx;
        sz       = unit_bytes();
        n        = pool_blocks();
        o.status = ST_OK;
        o.addr   = '0;
        if (kind == OP_ALLOC)
        begin
            if (nfree == 0)
                o.status = ST_EMPTY;
            else
            begin
                wide            = cfg_base + top_idx * sz;
                o.addr          = wide[BASE_W-1:0];
                is_free[top_idx] = 1'b0;
                top_idx         = link_of[top_idx];
                nfree--;
            end
        end
        else
        begin
            // The offset wraps modulo the address width, so addresses below the base
            // land far out of range.
            diff = addr - cfg_base;
            off  = diff;
            if (addr == '0)
                o.status = ST_INVALID;
            else if (off >= sz * n || (off % sz) != 0)
                o.status = ST_INVALID;
            else if (nfree >= n)
                o.status = ST_OVERFLOW;
            else
            begin
                idx = off / sz;
                if (is_free[idx])
                    o.status = ST_OVERFLOW;
                else
                begin
                    link_of[idx] = top_idx;
                    top_idx      = idx;
                    is_free[idx] = 1'b1;
                    nfree++;
                end
            end
        end
        o.count = nfree[CNT_W-1:0];
        o.avail = (nfree != 0);
        return o;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t fbpa_checker: %s", $time, what);
        fail_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            cfg_base  = RST_BASE;
            cfg_size  = RST_SIZE;
            cfg_count = RST_COUNT;
            rebuild_list();
            outcome_q.delete();
            pending_cnt = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_BASE:
                    begin
                        cfg_base = pwdata[BASE_W-1:0];
                        rebuild_list();
                    end
                    REG_SIZE:
                    begin
                        cfg_size = pwdata[SIZE_W-1:0];
                        rebuild_list();
                    end
                    REG_COUNT:
                    begin
                        cfg_count = pwdata[CNT_W-1:0];
                        rebuild_list();
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (rsp_valid && rsp_ready)
            begin
                if (pending_cnt == 0)
                    report_mismatch("response beat with no request outstanding");
                else
                begin
                    want = outcome_q.pop_front();
                    pending_cnt--;
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (block_address !== want.addr)
                        report_mismatch($sformatf("block_address %h, expected %h",
                                                  block_address, want.addr));
                    if (free_count !== want.count)
                        report_mismatch($sformatf("free_count %0d, expected %0d",
                                                  free_count, want.count));
                    if (available !== want.avail)
                        report_mismatch($sformatf("available %b, expected %b",
                                                  available, want.avail));
                end
            end

            if (req_valid && req_ready)
            begin
                outcome_q.push_back(predict_pool_op(op_t'(op), free_address));
                pending_cnt++;
            end
        end
    end

endmodule

### verif/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 100ps
// Testbench top for the block pool allocator: clock, reset, stimulus and verdict.
module fixed_block_pool_allocator_tb;
    import fbpa_pkg::*;

    // Longest legal quiet stretch is a clearing pass plus a long sender gap, the
    // block's own latency and a long receiver stall; this is many times that.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 150;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;

    logic               req_valid    = 1'b0;
    logic               req_ready;
    logic               op           = 1'b0;
    logic [BASE_W-1:0]  free_address = '0;

    logic               rsp_valid;
    logic               rsp_ready    = 1'b0;
    logic [1:0]         status;
    logic [BASE_W-1:0]  block_address;
    logic [CNT_W-1:0]   free_count;
    logic               available;

    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [PDATA_W-1:0] pwdata       = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 errors;
    int                 outstanding;
    int                 idle_cycles  = 0;
    int                 stall_left   = 0;

    // While quiet is set, neither side inserts gaps or stalls.
    bit                 quiet        = 1'b0;

    // Copy of the last values written, used only to aim free addresses at real blocks.
    logic [BASE_W-1:0]  pool_base    = RST_BASE;
    logic [SIZE_W-1:0]  pool_size    = RST_SIZE;
    logic [CNT_W-1:0]   pool_count   = RST_COUNT;

    fixed_block_pool_allocator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .op            (op),
        .free_address  (free_address),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .block_address (block_address),
        .free_count    (free_count),
        .available     (available),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // The checker watches both channels and the register port and predicts every beat.
    fbpa_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .op            (op),
        .free_address  (free_address),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .block_address (block_address),
        .free_count    (free_count),
        .available     (available),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .errors        (errors),
        .in_flight     (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned cur_size();
        return (pool_size < MIN_SIZE) ? MIN_SIZE : pool_size;
    endfunction

    function automatic int unsigned cur_count();
        return (pool_count > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : pool_count;
    endfunction

    function automatic logic [BASE_W-1:0] slot_addr(input int unsigned idx);
        return pool_base + idx * cur_size();
    endfunction

    // The receiver drops ready for random stretches, independent of rsp_valid, so
    // stalls land both on an idle output and on a waiting response.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // Any accepted beat, request, response or register write, counts as progress.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Presents one request beat after a random gap and returns in the cycle it is
    // taken. Valid stays high into the next call when that call picks no gap.
    task automatic issue_request(input op_t kind, input logic [BASE_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        op           <= kind;
        free_address <= addr;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Stops sending and waits until every expected response has been taken and the
    // block is back to accepting requests. Sampling on the falling edge keeps the
    // decision clear of the checker's updates on the rising edge.
    task automatic wait_for_responses();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0 || !req_ready);
        @(posedge clk);
    endtask

    // Setup cycle, access cycle, then wait out the clearing pass that a write to a
    // defined register starts, so that the next write never lands inside it.
    task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE:  pool_base  = val[BASE_W-1:0];
            REG_SIZE:  pool_size  = val[SIZE_W-1:0];
            REG_COUNT: pool_count = val[CNT_W-1:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
        do
            @(negedge clk);
        while (!req_ready);
        @(posedge clk);
    endtask

    // New pool geometry for a phase. Counts are mostly small so that the pool runs
    // both empty and full; a few phases use the largest settings.
    task automatic shuffle_config();
        logic [2:0]         pick;
        logic [PDATA_W-1:0] val;
        pick = $urandom_range(1, 7);
        if (pick[0])
        begin
            case ($urandom_range(0, 3))
                0:       val = $urandom();
                1:       val = 32'hFFFF_FFFF - $urandom_range(0, 4096);
                2:       val = $urandom_range(0, 65535);
                default: val = $urandom() & 32'hFFFF_FFF0;
            endcase
            apb_write(REG_BASE, val);
        end
        if (pick[1])
        begin
            val = $urandom() & 32'hFFFF_0000;
            case ($urandom_range(0, 3))
                0:       val[SIZE_W-1:0] = $urandom_range(0, 7);
                1, 2:    val[SIZE_W-1:0] = $urandom_range(4, 64);
                default: val[SIZE_W-1:0] = $urandom_range(0, 1) ? 16'hFFFF : $urandom();
            endcase
            apb_write(REG_SIZE, val);
        end
        if (pick[2])
        begin
            val = $urandom() & ~32'h1FF;
            case ($urandom_range(0, 4))
                0:       val[CNT_W-1:0] = $urandom_range(1, 6);
                1, 2:    val[CNT_W-1:0] = $urandom_range(7, 24);
                3:
                begin
                    case ($urandom_range(0, 3))
                        0:       val[CNT_W-1:0] = 9'd256;
                        1:       val[CNT_W-1:0] = 9'd0;
                        2:       val[CNT_W-1:0] = 9'd1;
                        default: val[CNT_W-1:0] = $urandom_range(257, 511);
                    endcase
                end
                default: val[CNT_W-1:0] = $urandom_range(0, 511);
            endcase
            apb_write(REG_COUNT, val);
        end
        // The unused address must be ignored without rebuilding the list.
        if ($urandom_range(0, 3) == 0)
            apb_write(REG_NONE, $urandom());
    endtask

    // Most frees name a real block of the current pool; the rest are zero,
    // misaligned, past the end, just below the base or fully random.
    task automatic random_item(input int alloc_pct);
        int unsigned       n;
        int unsigned       sz;
        logic [BASE_W-1:0] a;
        n  = cur_count();
        sz = cur_size();
        a  = $urandom();
        if ($urandom_range(0, 99) < alloc_pct)
            issue_request(OP_ALLOC, a);
        else
        begin
            if ($urandom_range(0, 99) < 75 && n > 0)
                a = slot_addr($urandom_range(0, n - 1));
            else
            begin
                case ($urandom_range(0, 4))
                    0:       a = '0;
                    1:       a = slot_addr($urandom_range(0, n)) + $urandom_range(1, sz - 1);
                    2:       a = slot_addr(n + $urandom_range(0, 3));
                    3:       a = pool_base - $urandom_range(1, sz);
                    default:
                    begin
                    end
                endcase
            end
            issue_request(OP_FREE, a);
        end
    endtask

    initial
    begin
        int alloc_pct;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: base 0x1000, 16-byte blocks, 256 of them, all free.
        issue_request(OP_FREE, '0);                 // zero address
        issue_request(OP_FREE, 32'h0000_1000);      // pool already full
        issue_request(OP_ALLOC, '0);                // highest block first
        issue_request(OP_ALLOC, '0);
        issue_request(OP_FREE, 32'h0000_1008);      // misaligned
        issue_request(OP_FREE, 32'h0000_2000);      // one past the last block
        issue_request(OP_FREE, 32'h0000_0FFF);      // below the base, offset wraps
        issue_request(OP_FREE, 32'h0000_1030);      // block that is still free
        issue_request(OP_FREE, 32'h0000_1FF0);      // good free of the top block
        issue_request(OP_FREE, 32'hFFFF_FFFF);
        issue_request(OP_ALLOC, 32'hFFFF_FFFF);     // address ignored, LIFO reuse

        // A single block: allocate it, run empty, give it back, then free twice.
        wait_for_responses();
        apb_write(REG_COUNT, 32'd1);
        issue_request(OP_ALLOC, '0);
        issue_request(OP_ALLOC, '0);
        issue_request(OP_FREE, 32'h0000_1000);
        issue_request(OP_FREE, 32'h0000_1000);

        // Size zero is taken as four; the second block wraps to address zero,
        // which a free must then reject.
        wait_for_responses();
        apb_write(REG_SIZE, 32'd0);
        apb_write(REG_BASE, 32'hFFFF_FFFC);
        apb_write(REG_COUNT, 32'd2);
        issue_request(OP_ALLOC, '0);
        issue_request(OP_FREE, '0);
        issue_request(OP_ALLOC, '0);
        issue_request(OP_ALLOC, '0);

        // An empty pool: nothing to hand out and no valid address.
        wait_for_responses();
        apb_write(REG_COUNT, 32'd0);
        issue_request(OP_ALLOC, '0);
        issue_request(OP_FREE, 32'hFFFF_FFFC);

        // Largest block size with a count above the maximum, which clamps to 256.
        wait_for_responses();
        apb_write(REG_SIZE, 32'hFFFF_FFFF);
        apb_write(REG_BASE, 32'h1234_5678);
        apb_write(REG_COUNT, 32'hFFFF_FFFF);
        issue_request(OP_ALLOC, '0);
        wait_for_responses();
        apb_write(REG_NONE, $urandom());
        issue_request(OP_ALLOC, '0);
        issue_request(OP_FREE, slot_addr(255));

        // Random phases, each with a fresh geometry and its own alloc/free mix.
        // Every fourth phase runs with no gaps or stalls at all.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_for_responses();
            quiet = (ph % 4 == 1);
            shuffle_config();
            alloc_pct = $urandom_range(35, 65);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Once in the run the sender holds off until everything has drained.
                if (ph == 5 && k == PHASE_ITEMS / 2)
                    wait_for_responses();
                random_item(alloc_pct);
            end
        end

        wait_for_responses();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
